FILE: hdl/pcs_pkg.sv
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared types and constants of the PID controller step block: request codes,
// register indexes, mode flag bits and the payload structs of both channels.
// ----------------------------------------------------------------------------
package pcs_pkg;

    // Request codes of the input channel.
    localparam logic [1:0] REQ_SAMPLE      = 2'd0;
    localparam logic [1:0] REQ_ENTER_AUTO  = 2'd1;
    localparam logic [1:0] REQ_ENTER_MAN   = 2'd2;
    localparam logic [1:0] REQ_RESET_INTEG = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_PROP_GAIN  = 3'd0;
    localparam logic [2:0] REG_INTEG_GAIN = 3'd1;
    localparam logic [2:0] REG_DERIV_GAIN = 3'd2;
    localparam logic [2:0] REG_OUT_MIN    = 3'd3;
    localparam logic [2:0] REG_OUT_MAX    = 3'd4;
    localparam logic [2:0] REG_MODE_FLAGS = 3'd5;
    localparam logic [2:0] REG_ALPHA      = 3'd6;
    localparam logic [2:0] REG_INTEG_LIM  = 3'd7;

    // Bit positions inside the mode flags register.
    localparam int FLAG_P_ON_MEAS = 0;
    localparam int FLAG_D_FILTER  = 1;
    localparam int FLAG_COND_I    = 2;
    localparam int FLAG_REVERSE   = 3;

    // Filter weight constants, Q1.16.
    localparam logic [16:0] ALPHA_ONE      = 17'd65536;
    localparam logic [16:0] ALPHA_FALLBACK = 17'd6554;

    // Reset value of the upper clamp, 255.0 in Q16.16.
    localparam logic signed [31:0] OUT_MAX_RESET = 32'sd16711680;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] measured;
        logic signed [31:0] target;
        logic signed [31:0] present_output;
    } t_pcs_in;

    typedef struct packed {
        logic signed [31:0] control_output;
        logic               computed;
    } t_pcs_out;

endpackage

FILE: hdl/pcs_mul.sv
// ----------------------------------------------------------------------------
// pcs_mul
// Shared signed 32 x 18 bit multiplier with a registered product.
// ----------------------------------------------------------------------------
module pcs_mul import pcs_pkg::*; (
    input  logic               i_clk,
    input  logic signed [31:0] i_a,
    input  logic signed [17:0] i_b,
    output logic signed [49:0] o_prod
);

    logic signed [49:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

FILE: hdl/pcs_clamp.sv
// ----------------------------------------------------------------------------
// pcs_clamp
// Clamps a wide signed value to the output limits. When the two limits cross,
// a value above the upper limit takes it and any other value the lower limit.
// ----------------------------------------------------------------------------
module pcs_clamp import pcs_pkg::*; (
    input  logic signed [51:0] i_value,
    input  logic signed [31:0] i_min,
    input  logic signed [31:0] i_max,
    output logic signed [31:0] o_value
);

    logic signed [51:0] w_min;
    logic signed [51:0] w_max;

    assign w_min = {{20{i_min[31]}}, i_min};
    assign w_max = {{20{i_max[31]}}, i_max};

    always_comb begin
        priority if (i_value > w_max) begin
            o_value = i_max;
        end else if (i_value < w_min) begin
            o_value = i_min;
        end else begin
            o_value = i_value[31:0];
        end
    end

endmodule

FILE: hdl/pid_controller_step.sv
// ----------------------------------------------------------------------------
// pid_controller_step
// Discrete PID controller step in signed Q16.16 with integrator anti-windup,
// built around one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// Usage: each transaction on the input channel (i_valid, o_ready, i_data)
// carries a request: a sample, enter automatic, enter manual or reset the
// integral. Every request yields exactly one transaction on the output channel
// (o_valid, i_ready, o_data). A sample in automatic mode returns the clamped
// drive value with computed set; all other requests return zero.
// The block takes one request at a time. A sample in automatic mode passes
// through dispatch, the filter states when the input filter is on, the
// derivative input step, the multiply program and done; any other request
// goes from dispatch straight to done. With the receiver keeping up, the
// sequencer returns to idle as the output register loads, and the next
// request can then be accepted. Samples are paced by the shared 32 x 18 bit
// multiplier, which is used for two partial products per gain term and two
// for the filter, one product per cycle.
// A finished result sits in the output register, and the next request is
// accepted while it waits. When the receiver stalls, a second result waits
// in the sequencer until the output register frees up.
// Configuration registers are written through i_cfg_we, i_cfg_idx and
// i_cfg_wdata, and should only be written while the block is idle.
// Synchronous reset (i_rst_n low) restores the register defaults, selects
// manual mode and clears the controller state and both channels.
// ----------------------------------------------------------------------------
module pid_controller_step import pcs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_pcs_in     i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_pcs_out    o_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata
);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DISP  = 3'd1;
    localparam logic [2:0] ST_FILT1 = 3'd2;
    localparam logic [2:0] ST_FILT2 = 3'd3;
    localparam logic [2:0] ST_FILT3 = 3'd4;
    localparam logic [2:0] ST_DIN   = 3'd5;
    localparam logic [2:0] ST_MUL   = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    // Last step of the multiply program.
    localparam logic [3:0] K_LAST = 4'd10;

    // Configuration registers.
    logic [30:0]        r_prop_gain;
    logic [30:0]        r_integ_gain;
    logic [30:0]        r_deriv_gain;
    logic signed [31:0] r_out_min;
    logic signed [31:0] r_out_max;
    logic [3:0]         r_flags;
    logic [16:0]        r_alpha;
    logic [30:0]        r_integ_lim;

    // Controller state.
    logic               r_auto;
    logic               r_first;
    logic               r_prev_pos;
    logic signed [31:0] r_isum;
    logic signed [31:0] r_prev;
    logic signed [31:0] r_smooth;

    // Sequencer and datapath.
    logic [2:0]         r_state;
    logic [2:0]         n_state;
    logic [3:0]         r_k;
    t_pcs_in            r_in;
    logic signed [51:0] r_acc;
    logic [30:0]        r_lo;
    logic signed [32:0] r_err;
    logic signed [32:0] r_din;
    logic               r_ien;
    logic signed [31:0] r_res;
    logic               r_comp;
    logic               r_ovalid;
    t_pcs_out           r_out;

    logic signed [32:0] w_err;
    logic               w_pos;
    logic [32:0]        w_aerr;
    logic               w_ien;
    logic [16:0]        w_alpha;
    logic [16:0]        w_alpha_c;
    logic signed [31:0] w_dsrc;
    logic signed [31:0] m_a;
    logic signed [17:0] m_b;
    logic signed [49:0] w_prod;
    logic [30:0]        w_gain;
    logic signed [32:0] w_val;
    logic               w_hi;
    logic               w_add_en;
    logic               w_neg;
    logic signed [51:0] w_term;
    logic signed [51:0] w_acc_add;
    logic signed [51:0] w_fsum;
    logic signed [51:0] c_in;
    logic signed [31:0] c_out;
    logic               w_accept;
    logic               w_load_out;

    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;
    assign o_valid  = r_ovalid;
    assign o_data   = r_out;

    // The output register takes a result when it is empty or being emptied.
    assign w_load_out = (r_state == ST_DONE) && (!r_ovalid || i_ready);

    // Error of the captured sample and the conditions derived from it.
    assign w_err  = {r_in.target[31], r_in.target}
                  - {r_in.measured[31], r_in.measured};
    assign w_pos  = !w_err[32] && (w_err != 33'sd0);
    assign w_aerr = w_err[32] ? 33'(-w_err) : 33'(w_err);
    assign w_ien  = !r_flags[FLAG_COND_I] || (w_aerr <= {2'b00, r_integ_lim});

    // An out-of-range filter weight falls back to 0.1.
    assign w_alpha   = ((r_alpha == 17'd0) || (r_alpha > ALPHA_ONE))
                     ? ALPHA_FALLBACK : r_alpha;
    assign w_alpha_c = ALPHA_ONE - w_alpha;

    // Input of the derivative path: the filtered or the raw measurement.
    assign w_dsrc = r_flags[FLAG_D_FILTER] ? r_smooth : r_in.measured;

    // Multiply program. Each gain term takes a low partial product (the lower
    // 16 value bits, unsigned) and then a high one (the upper 17 bits, signed).
    // The low product is consumed in the cycle after it is issued, and so is the
    // high one, when the term is added into the accumulator.
    always_comb begin
        w_gain   = r_integ_gain;
        w_val    = r_err;
        w_hi     = 1'b0;
        w_add_en = 1'b0;
        w_neg    = 1'b0;
        unique case (r_k)
            4'd0: begin
                w_gain = r_integ_gain;
                w_val  = r_err;
            end
            4'd1: begin
                w_gain = r_integ_gain;
                w_val  = r_err;
                w_hi   = 1'b1;
            end
            4'd2: begin
                w_gain   = r_prop_gain;
                w_val    = r_din;
                w_add_en = r_ien;
                w_neg    = r_flags[FLAG_REVERSE];
            end
            4'd3: begin
                w_gain = r_prop_gain;
                w_val  = r_din;
                w_hi   = 1'b1;
            end
            4'd4: begin
                // Proportional on measurement is taken off the integrator.
                w_add_en = r_flags[FLAG_P_ON_MEAS];
                w_neg    = !r_flags[FLAG_REVERSE];
            end
            4'd5: begin
                w_gain = r_prop_gain;
                w_val  = r_err;
            end
            4'd6: begin
                w_gain = r_prop_gain;
                w_val  = r_err;
                w_hi   = 1'b1;
            end
            4'd7: begin
                w_gain   = r_deriv_gain;
                w_val    = r_din;
                w_add_en = !r_flags[FLAG_P_ON_MEAS];
                w_neg    = r_flags[FLAG_REVERSE];
            end
            4'd8: begin
                w_gain = r_deriv_gain;
                w_val  = r_din;
                w_hi   = 1'b1;
            end
            4'd9: begin
                w_add_en = 1'b1;
                w_neg    = !r_flags[FLAG_REVERSE];
            end
            default: begin
                w_gain = r_integ_gain;
            end
        endcase
    end

    // Operand selection of the shared multiplier.
    always_comb begin
        m_a = 32'sd0;
        m_b = 18'sd0;
        unique case (r_state)
            ST_FILT1: begin
                m_a = r_in.measured;
                m_b = {1'b0, w_alpha};
            end
            ST_FILT2: begin
                m_a = r_smooth;
                m_b = {1'b0, w_alpha_c};
            end
            ST_MUL: begin
                m_a = {1'b0, w_gain};
                m_b = w_hi ? {w_val[32], w_val[32:16]} : {2'b00, w_val[15:0]};
            end
            default: begin
                m_a = 32'sd0;
                m_b = 18'sd0;
            end
        endcase
    end

    pcs_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (m_a),
        .i_b    (m_b),
        .o_prod (w_prod)
    );

    // Floor of gain times value over 2^16: the high product plus the low
    // product shifted down, which is never negative.
    assign w_term    = {{2{w_prod[49]}}, w_prod} + {21'd0, r_lo};
    assign w_acc_add = r_acc + (w_neg ? -w_term : w_term);
    assign w_fsum    = r_acc + {{2{w_prod[49]}}, w_prod};

    assign c_in = (r_state == ST_DISP)
                ? {{20{r_in.present_output[31]}}, r_in.present_output}
                : r_acc;

    pcs_clamp u_clamp (
        .i_value (c_in),
        .i_min   (r_out_min),
        .i_max   (r_out_max),
        .o_value (c_out)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_DISP;
                end
            end
            ST_DISP: begin
                if ((r_in.req_type == REQ_SAMPLE) && r_auto) begin
                    n_state = r_flags[FLAG_D_FILTER] ? ST_FILT1 : ST_DIN;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_FILT1: n_state = ST_FILT2;
            ST_FILT2: n_state = ST_FILT3;
            ST_FILT3: n_state = ST_DIN;
            ST_DIN:   n_state = ST_MUL;
            ST_MUL: begin
                if (r_k == K_LAST) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_k          <= 4'd0;
            r_ovalid     <= 1'b0;
            r_prop_gain  <= 31'd0;
            r_integ_gain <= 31'd0;
            r_deriv_gain <= 31'd0;
            r_out_min    <= 32'sd0;
            r_out_max    <= OUT_MAX_RESET;
            r_flags      <= 4'd0;
            r_alpha      <= ALPHA_FALLBACK;
            r_integ_lim  <= 31'd0;
            r_auto       <= 1'b0;
            r_first      <= 1'b0;
            r_prev_pos   <= 1'b0;
            r_isum       <= 32'sd0;
            r_prev       <= 32'sd0;
            r_smooth     <= 32'sd0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_PROP_GAIN:  r_prop_gain  <= i_cfg_wdata[30:0];
                    REG_INTEG_GAIN: r_integ_gain <= i_cfg_wdata[30:0];
                    REG_DERIV_GAIN: r_deriv_gain <= i_cfg_wdata[30:0];
                    REG_OUT_MIN:    r_out_min    <= i_cfg_wdata;
                    REG_OUT_MAX:    r_out_max    <= i_cfg_wdata;
                    REG_MODE_FLAGS: r_flags      <= i_cfg_wdata[3:0];
                    REG_ALPHA:      r_alpha      <= i_cfg_wdata[16:0];
                    REG_INTEG_LIM:  r_integ_lim  <= i_cfg_wdata[30:0];
                    default: ;
                endcase
            end

            if (w_accept) begin
                r_in <= i_data;
            end

            if (w_load_out) begin
                r_out    <= '{control_output: r_res, computed: r_comp};
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                ST_DISP: begin
                    r_res  <= 32'sd0;
                    r_comp <= 1'b0;
                    r_err  <= w_err;
                    r_ien  <= w_ien;
                    unique case (r_in.req_type)
                        REQ_SAMPLE: begin
                            if (r_auto) begin
                                if (r_first) begin
                                    // First sample after entering automatic.
                                    r_prev     <= r_in.measured;
                                    r_smooth   <= r_in.measured;
                                    r_prev_pos <= w_pos;
                                    r_first    <= 1'b0;
                                end else if (w_pos != r_prev_pos) begin
                                    // Error changed sign: drop the integrator.
                                    r_isum <= 32'sd0;
                                end
                            end
                        end
                        REQ_ENTER_AUTO: begin
                            if (!r_auto) begin
                                // Bumpless transfer from the actuator value.
                                r_isum   <= c_out;
                                r_prev   <= r_in.measured;
                                r_smooth <= r_in.measured;
                                r_first  <= 1'b1;
                            end
                            r_auto <= 1'b1;
                        end
                        REQ_ENTER_MAN: begin
                            r_auto <= 1'b0;
                        end
                        REQ_RESET_INTEG: begin
                            r_isum   <= 32'sd0;
                            r_prev   <= r_in.measured;
                            r_smooth <= r_in.measured;
                            r_first  <= 1'b0;
                        end
                        default: ;
                    endcase
                end
                ST_FILT2: begin
                    r_acc <= {{2{w_prod[49]}}, w_prod};
                end
                ST_FILT3: begin
                    r_smooth <= w_fsum[47:16];
                end
                ST_DIN: begin
                    r_din <= {w_dsrc[31], w_dsrc} - {r_prev[31], r_prev};
                    r_acc <= {{20{r_isum[31]}}, r_isum};
                    r_k   <= 4'd0;
                end
                ST_MUL: begin
                    r_k <= r_k + 4'd1;
                    unique case (r_k)
                        4'd1, 4'd3, 4'd6, 4'd8: begin
                            r_lo <= w_prod[46:16];
                        end
                        4'd2, 4'd4, 4'd7, 4'd9: begin
                            if (w_add_en) begin
                                r_acc <= w_acc_add;
                            end
                        end
                        4'd5: begin
                            // Clamped integrator, then the output terms on top.
                            r_isum <= c_out;
                            r_acc  <= {{20{c_out[31]}}, c_out};
                        end
                        4'd10: begin
                            r_res      <= c_out;
                            r_comp     <= 1'b1;
                            r_prev     <= w_dsrc;
                            r_prev_pos <= !r_err[32] && (r_err != 33'sd0);
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

`ifndef ASSERT_OFF
    // A result that was not computed carries a zero drive value.
    a_zero_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.computed) |-> (o_data.control_output == 32'sd0))
        else $error("uncomputed result with non-zero output");

    // An accepted transaction is dispatched in the next cycle.
    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == ST_DISP))
        else $error("accepted transaction not dispatched");

    // The multiply program never runs past its last step.
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |-> (r_k <= K_LAST))
        else $error("multiply step out of range");
`endif

endmodule
